// File: hdl/ume_pkg.sv
// ume_pkg: word types, opcodes, status codes and control structs
// for the universal machine execute unit
// depends on: nothing
`default_nettype none

package ume_pkg;

    // incoming word
    typedef struct packed {
        logic        op;
        logic [31:0] instr;
        logic [7:0]  in_char;
        logic        in_eof;
        logic [2:0]  wb_reg;
        logic [31:0] wb_value;
    } item_t;

    // outgoing word
    typedef struct packed {
        logic [2:0]  status;
        logic        out_valid;
        logic [7:0]  out_char;
        logic [3:0]  fwd_opcode;
        logic [2:0]  fwd_dest;
        logic [31:0] val_a;
        logic [31:0] val_b;
        logic [31:0] val_c;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic read_a;
        logic div_start;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_div;
        logic need_a;
        logic div_done;
        logic out_free;
        logic stopped;
    } stat_t;

    // item kinds
    localparam logic OPK_EXEC = 1'b0;
    localparam logic OPK_WB   = 1'b1;

    // opcodes
    localparam logic [3:0] OPC_CMOV  = 4'd0;
    localparam logic [3:0] OPC_LOAD  = 4'd1;
    localparam logic [3:0] OPC_STORE = 4'd2;
    localparam logic [3:0] OPC_ADD   = 4'd3;
    localparam logic [3:0] OPC_MUL   = 4'd4;
    localparam logic [3:0] OPC_DIV   = 4'd5;
    localparam logic [3:0] OPC_NAND  = 4'd6;
    localparam logic [3:0] OPC_HALT  = 4'd7;
    localparam logic [3:0] OPC_NEW   = 4'd8;
    localparam logic [3:0] OPC_DEL   = 4'd9;
    localparam logic [3:0] OPC_OUT   = 4'd10;
    localparam logic [3:0] OPC_IN    = 4'd11;
    localparam logic [3:0] OPC_PROG  = 4'd12;
    localparam logic [3:0] OPC_LDI   = 4'd13;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_HALT    = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_DIVZERO = 3'd3;
    localparam logic [2:0] ST_BADCHAR = 3'd4;
    localparam logic [2:0] ST_FORWARD = 3'd5;
    localparam logic [2:0] ST_STOPPED = 3'd6;

    // instruction word layout
    localparam int OPC_LSB    = 28;
    localparam int IMM_REG_LSB = 25;
    localparam int IMM_BITS   = 25;
    localparam logic [31:0] CHAR_MAX = 32'h0000_00ff;

endpackage

`default_nettype wire

// File: hdl/ume_div.sv
// ume_div: restoring unsigned divider, one quotient bit per cycle
// depends on: nothing
`default_nettype none

module ume_div
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);

    localparam int          STEPS    = 32;
    localparam logic [4:0]  LAST_CNT = 5'(STEPS - 1);

    logic        run_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dsr_reg;

    logic [32:0] shifted;
    logic        ge;
    logic [32:0] diff;

    // one trial subtraction
    always_comb
    begin
        shifted = {rem_reg, quo_reg[31]};
        ge      = shifted >= {1'b0, dsr_reg};
        diff    = shifted - {1'b0, dsr_reg};
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == LAST_CNT)
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[31:0] : shifted[31:0];
            quo_reg <= {quo_reg[30:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: hdl/ume_dpath.sv
// ume_dpath: item register, register file, alu, divider and result register
// depends on: ume_pkg, ume_div
`default_nettype none

module ume_dpath
    import ume_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire item_t   item_in,
    input  wire cmd_t    cmd,
    output stat_t        stat,
    input  wire logic    res_stall,
    output logic         res_valid,
    output result_t      res_word
);

    item_t       item_reg;
    logic [31:0] rf_reg [8];
    logic [7:0]  vld_reg;
    logic [31:0] ra_mem_reg;
    logic [31:0] rb_mem_reg;
    logic [31:0] rc_mem_reg;
    logic        ra_ok_reg;
    logic        rb_ok_reg;
    logic        rc_ok_reg;
    logic        stopped_reg;
    logic        out_vld_reg;
    result_t     out_reg;

    logic [3:0]  opc;
    logic [2:0]  ia;
    logic [2:0]  ib;
    logic [2:0]  ic;
    logic [31:0] ra;
    logic [31:0] rb;
    logic [31:0] rc;
    logic [2:0]  rd0_addr;
    logic [31:0] prod;
    logic        div_done;
    logic [31:0] quot;

    result_t     res;
    logic        wr_en;
    logic [2:0]  wr_addr;
    logic [31:0] wr_data;
    logic        set_stop;
    logic        is_fwd;

    assign opc = item_reg.instr[31:OPC_LSB];
    assign ia  = item_reg.instr[8:6];
    assign ib  = item_reg.instr[5:3];
    assign ic  = item_reg.instr[2:0];

    // entries never written read as zero
    assign ra = ra_ok_reg ? ra_mem_reg : '0;
    assign rb = rb_ok_reg ? rb_mem_reg : '0;
    assign rc = rc_ok_reg ? rc_mem_reg : '0;

    assign prod = rb * rc;

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_reg <= item_in;
        end
    end

    // register file: port 0 reads B at capture or A later, port 1 reads C
    assign rd0_addr = cmd.read_a ? ia : item_in.instr[5:3];

    always_ff @(posedge clk)
    begin
        if (wr_en && cmd.commit)
        begin
            rf_reg[wr_addr] <= wr_data;
        end
        if (cmd.latch || cmd.read_a)
        begin
            if (cmd.read_a)
            begin
                ra_mem_reg <= rf_reg[rd0_addr];
                ra_ok_reg  <= vld_reg[rd0_addr];
            end
            else
            begin
                rb_mem_reg <= rf_reg[rd0_addr];
                rb_ok_reg  <= vld_reg[rd0_addr];
            end
        end
        if (cmd.latch)
        begin
            rc_mem_reg <= rf_reg[item_in.instr[2:0]];
            rc_ok_reg  <= vld_reg[item_in.instr[2:0]];
        end
    end

    // per-entry valid bits stand in for the zero reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en && cmd.commit)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // divider
    ume_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rb),
        .divisor  (rc),
        .done     (div_done),
        .quotient (quot)
    );

    // result and register write for the captured item
    always_comb
    begin
        res      = '0;
        res.status = ST_OK;
        wr_en    = 1'b0;
        wr_addr  = ia;
        wr_data  = '0;
        set_stop = 1'b0;
        is_fwd   = 1'b0;
        if (item_reg.op == OPK_WB)
        begin
            wr_en   = 1'b1;
            wr_addr = item_reg.wb_reg;
            wr_data = item_reg.wb_value;
        end
        else if (stopped_reg)
        begin
            res.status = ST_STOPPED;
        end
        else
        begin
            case (opc)
                OPC_CMOV:
                begin
                    wr_en   = rc != '0;
                    wr_data = rb;
                end
                OPC_ADD:
                begin
                    wr_en   = 1'b1;
                    wr_data = rb + rc;
                end
                OPC_MUL:
                begin
                    wr_en   = 1'b1;
                    wr_data = prod;
                end
                OPC_DIV:
                begin
                    if (rc == '0)
                    begin
                        set_stop   = 1'b1;
                        res.status = ST_DIVZERO;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_data = quot;
                    end
                end
                OPC_NAND:
                begin
                    wr_en   = 1'b1;
                    wr_data = ~(rb & rc);
                end
                OPC_HALT:
                begin
                    set_stop   = 1'b1;
                    res.status = ST_HALT;
                end
                OPC_OUT:
                begin
                    if (rc > CHAR_MAX)
                    begin
                        set_stop   = 1'b1;
                        res.status = ST_BADCHAR;
                    end
                    else
                    begin
                        res.out_valid = 1'b1;
                        res.out_char  = rc[7:0];
                    end
                end
                OPC_IN:
                begin
                    wr_en   = 1'b1;
                    wr_addr = ic;
                    wr_data = item_reg.in_eof ? '1 : {24'd0, item_reg.in_char};
                end
                OPC_LDI:
                begin
                    wr_en   = 1'b1;
                    wr_addr = item_reg.instr[IMM_REG_LSB +: 3];
                    wr_data = {7'd0, item_reg.instr[IMM_BITS-1:0]};
                end
                OPC_LOAD, OPC_STORE, OPC_NEW, OPC_DEL, OPC_PROG:
                begin
                    is_fwd         = 1'b1;
                    res.status     = ST_FORWARD;
                    res.fwd_opcode = opc;
                    res.fwd_dest   = (opc == OPC_LOAD) ? ia :
                                     ((opc == OPC_NEW) ? ib : 3'd0);
                    res.val_a      = ra;
                    res.val_b      = rb;
                    res.val_c      = rc;
                end
                default:
                begin
                    set_stop   = 1'b1;
                    res.status = ST_INVALID;
                end
            endcase
        end
    end

    // stopped flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopped_reg <= 1'b0;
        end
        else if (cmd.commit && set_stop)
        begin
            stopped_reg <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_reg <= res;
        end
    end

    // status back to the controller
    always_comb
    begin
        stat.need_div = (item_reg.op == OPK_EXEC) && !stopped_reg
                        && (opc == OPC_DIV) && (rc != '0);
        stat.need_a   = (item_reg.op == OPK_EXEC) && !stopped_reg && is_fwd;
        stat.div_done = div_done;
        stat.out_free = !out_vld_reg || !res_stall;
        stat.stopped  = stopped_reg;
    end

    assign res_valid = out_vld_reg;
    assign res_word  = out_reg;

endmodule

`default_nettype wire

// File: hdl/ume_ctrl.sv
// ume_ctrl: sequencing of capture, register reads, divide and commit
// depends on: ume_pkg
`default_nettype none

module ume_ctrl
    import ume_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cmd_valid,
    output logic        cmd_stall,
    input  wire stat_t  stat,
    output cmd_t        cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_RDA  = 3'd2;
    localparam logic [2:0] S_DIVW = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVW;
                end
                else if (stat.need_a)
                begin
                    cmd.read_a = 1'b1;
                    state_next = S_RDA;
                end
                else if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RDA, S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIVW:
            begin
                if (stat.div_done)
                begin
                    state_next = S_FIN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd_stall = state_reg != S_IDLE;

endmodule

`default_nettype wire

// File: hdl/universal_machine_execute.sv
// universal_machine_execute: top level of the execute unit
// depends on: ume_pkg, ume_ctrl, ume_dpath (which holds ume_div)
//
//  channel | valid     | stall     | word
//  --------+-----------+-----------+-----------------------------
//  command | cmd_valid | cmd_stall | cmd_word  (item_t, in)
//  result  | res_valid | res_stall | res_word  (result_t, out)
//
// one word at a time: most words go through capture with the B/C register read,
// then execute and commit; array forwards add a second register file read for
// A; a divide by a non-zero register goes through capture, start, 32 steps of
// the one-bit-per-cycle divider, wait on done, commit
// register file reset is handled by per-entry valid bits, no clearing pass
// the result register lets the next word be taken while a result is stalled;
// commit then waits until the result register is free
`default_nettype none

module universal_machine_execute
    import ume_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    cmd_valid,
    output logic         cmd_stall,
    input  wire item_t   cmd_word,
    output logic         res_valid,
    input  wire logic    res_stall,
    output result_t      res_word
);

    cmd_t  cmd;
    stat_t stat;

    // controller
    ume_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath
    ume_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_in   (cmd_word),
        .cmd       (cmd),
        .stat      (stat),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res_word  (res_word)
    );

    // an accepted word keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("block took a word but was not busy afterwards");

    // a commit never overwrites a stalled result
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(res_valid && res_stall))
        else $error("commit while the result register was held");

    // a halt result leaves the machine stopped
    a_halt_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_word.status == ST_HALT)) |-> stat.stopped)
        else $error("halt delivered but machine not stopped");

endmodule

`default_nettype wire

// File: tb/ume_exec_checker.sv
`timescale 1ns / 1ps
// ume_exec_checker: watches the command and result channels of the execute unit,
// keeps its own register file and stop flag, and checks every result word
// depends on: ume_pkg
module ume_exec_checker
    import ume_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  logic    cmd_stall,
    input  item_t   cmd_word,
    input  logic    res_valid,
    input  logic    res_stall,
    input  result_t res_word,
    output int      errors,
    output int      pending,
    output int      checked
);

    // register field positions inside an instruction word
    localparam int          A_LSB    = 6;
    localparam int          B_LSB    = 3;
    localparam int          C_LSB    = 0;
    localparam logic [31:0] IMM_MASK = (32'd1 << IMM_BITS) - 32'd1;

    logic [31:0] machine_regs [8];
    logic        machine_stopped;
    result_t     results_due [$];
    result_t     due;
    int          k;

    // work out the result of one command word and update the machine state
    function automatic result_t execute_word(input item_t w);
        result_t     r;
        logic [3:0]  opc;
        logic [2:0]  ia;
        logic [2:0]  ib;
        logic [2:0]  ic;
        logic [31:0] ra;
        logic [31:0] rb;
        logic [31:0] rc;
        r = '0;
        if (w.op == OPK_WB)
        begin
            machine_regs[w.wb_reg] = w.wb_value;
            r.status = ST_OK;
            return r;
        end
        if (machine_stopped)
        begin
            r.status = ST_STOPPED;
            return r;
        end
        opc = w.instr[OPC_LSB +: 4];
        ia  = w.instr[A_LSB +: 3];
        ib  = w.instr[B_LSB +: 3];
        ic  = w.instr[C_LSB +: 3];
        ra  = machine_regs[ia];
        rb  = machine_regs[ib];
        rc  = machine_regs[ic];
        r.status = ST_OK;
        case (opc)
            OPC_CMOV:
                if (rc != '0)
                    machine_regs[ia] = rb;
            OPC_ADD:
                machine_regs[ia] = rb + rc;
            OPC_MUL:
                machine_regs[ia] = rb * rc;
            OPC_DIV:
                if (rc == '0)
                begin
                    machine_stopped = 1'b1;
                    r.status = ST_DIVZERO;
                end
                else
                    machine_regs[ia] = rb / rc;
            OPC_NAND:
                machine_regs[ia] = ~(rb & rc);
            OPC_HALT:
            begin
                machine_stopped = 1'b1;
                r.status = ST_HALT;
            end
            OPC_OUT:
                if (rc > CHAR_MAX)
                begin
                    machine_stopped = 1'b1;
                    r.status = ST_BADCHAR;
                end
                else
                begin
                    r.out_valid = 1'b1;
                    r.out_char  = rc[7:0];
                end
            OPC_IN:
                machine_regs[ic] = w.in_eof ? '1 : {24'd0, w.in_char};
            OPC_LDI:
                machine_regs[w.instr[IMM_REG_LSB +: 3]] = w.instr & IMM_MASK;
            OPC_LOAD, OPC_STORE, OPC_NEW, OPC_DEL, OPC_PROG:
            begin
                // array operations go out with the register values they name
                r.status     = ST_FORWARD;
                r.fwd_opcode = opc;
                r.fwd_dest   = (opc == OPC_LOAD) ? ia : ((opc == OPC_NEW) ? ib : 3'd0);
                r.val_a      = ra;
                r.val_b      = rb;
                r.val_c      = rc;
            end
            default:
            begin
                machine_stopped = 1'b1;
                r.status = ST_INVALID;
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] seen,
                                   input logic [31:0] wanted);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, seen, wanted);
        errors++;
    endtask

    // compare accepted results first, then predict the word taken at this edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (k = 0; k < 8; k++)
                machine_regs[3'(k)] = '0;
            machine_stopped = 1'b0;
            results_due.delete();
            pending = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (results_due.size() == 0)
                    report_mismatch("result word with none due (status)",
                                    32'(res_word.status), '0);
                else
                begin
                    due = results_due.pop_front();
                    checked++;
                    if (res_word.status !== due.status)
                        report_mismatch("status", 32'(res_word.status),
                                        32'(due.status));
                    if (res_word.out_valid !== due.out_valid)
                        report_mismatch("out_valid", 32'(res_word.out_valid),
                                        32'(due.out_valid));
                    if (res_word.out_char !== due.out_char)
                        report_mismatch("out_char", 32'(res_word.out_char),
                                        32'(due.out_char));
                    if (res_word.fwd_opcode !== due.fwd_opcode)
                        report_mismatch("fwd_opcode", 32'(res_word.fwd_opcode),
                                        32'(due.fwd_opcode));
                    if (res_word.fwd_dest !== due.fwd_dest)
                        report_mismatch("fwd_dest", 32'(res_word.fwd_dest),
                                        32'(due.fwd_dest));
                    if (res_word.val_a !== due.val_a)
                        report_mismatch("val_a", res_word.val_a, due.val_a);
                    if (res_word.val_b !== due.val_b)
                        report_mismatch("val_b", res_word.val_b, due.val_b);
                    if (res_word.val_c !== due.val_c)
                        report_mismatch("val_c", res_word.val_c, due.val_c);
                end
            end
            if (cmd_valid && !cmd_stall)
                results_due.push_back(execute_word(cmd_word));
            pending = results_due.size();
        end
    end

endmodule

// File: tb/tb_universal_machine_execute.sv
`timescale 1ns / 1ps
// tb_universal_machine_execute: clock, reset and command/result traffic for the
// execute unit, with the checker instantiated beside it
// depends on: ume_pkg, universal_machine_execute, ume_exec_checker
module tb_universal_machine_execute;
    import ume_pkg::*;

    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         PHASE_WORDS  = 500;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         DRAIN_CYCLES = 64;
    localparam int         TAIL_WORDS   = 40;
    localparam logic [3:0] OPC_BAD_LO   = 4'd14;
    localparam logic [3:0] OPC_BAD_HI   = 4'd15;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    cmd_valid;
    logic    cmd_stall;
    item_t   cmd_word;
    logic    res_valid;
    logic    res_stall;
    result_t res_word;

    int      errors;
    int      pending;
    int      checked;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      words_sent;
    int      cycle_count;
    bit      hold_req;
    string   stop_kind;

    universal_machine_execute dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

    ume_exec_checker exec_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
        $display("FAIL universal_machine_execute");
        $finish;
    end

    // corner-heavy 32-bit values
    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return $urandom_range(1, 300);
            default: return $urandom();
        endcase
    endfunction

    // instruction word with random filler in every field it ignores
    function automatic item_t exec_word(input logic [3:0] opc, input logic [2:0] a,
                                        input logic [2:0] b, input logic [2:0] c);
        item_t w;
        w.op                = OPK_EXEC;
        w.instr             = $urandom();
        w.instr[OPC_LSB +: 4] = opc;
        w.instr[8:0]        = {a, b, c};
        w.in_char           = 8'($urandom_range(0, 255));
        w.in_eof            = 1'($urandom_range(0, 1));
        w.wb_reg            = 3'($urandom_range(0, 7));
        w.wb_value          = $urandom();
        return w;
    endfunction

    function automatic item_t wb_word(input logic [2:0] dst, input logic [31:0] value);
        item_t w;
        w          = exec_word(4'($urandom_range(0, 15)), 3'd0, 3'd0, 3'd0);
        w.op       = OPK_WB;
        w.wb_reg   = dst;
        w.wb_value = value;
        return w;
    endfunction

    function automatic item_t ldi_word(input logic [2:0] dst, input logic [24:0] imm);
        item_t w;
        w = exec_word(OPC_LDI, 3'd0, 3'd0, 3'd0);
        w.instr[IMM_REG_LSB +: 3]   = dst;
        w.instr[IMM_BITS - 1:0]     = imm;
        return w;
    endfunction

    // offer one word, with random idle cycles in front, until it is taken
    task automatic push_word(input item_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            cmd_word  <= exec_word(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                                   3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        words_sent++;
    endtask

    // result side: random stalls, plus one long hold when asked
    initial
    begin
        int held;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_stall <= 1'b1;
                for (held = 1; held < HOLD_CYCLES; held++)
                    @(posedge clk);
            end
            else
                res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // stimulus
    initial
    begin
        item_t       w;
        logic [3:0]  safe_ops [11];
        logic [2:0]  a;
        logic [2:0]  b;
        logic [2:0]  c;
        logic [31:0] divisor;
        int          pick;
        int          phase;
        int          phase_end;

        safe_ops = '{OPC_CMOV, OPC_LOAD, OPC_STORE, OPC_ADD, OPC_MUL, OPC_NAND,
                     OPC_NEW, OPC_DEL, OPC_IN, OPC_PROG, OPC_LDI};
        rst_n         <= 1'b0;
        cmd_valid     <= 1'b0;
        cmd_word      <= '0;
        send_idle_pct = 12;
        recv_idle_pct = 64;
        words_sent    = 0;
        hold_req      = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words: field extremes, wrap-around arithmetic, every opcode but halt
        push_word(ldi_word(3'd7, 25'h1ff_ffff));
        push_word(ldi_word(3'd0, 25'd0));
        push_word(wb_word(3'd1, 32'hffff_ffff));
        push_word(wb_word(3'd2, 32'd1));
        push_word(wb_word(3'd3, 32'h8000_0000));
        push_word(exec_word(OPC_ADD, 3'd4, 3'd1, 3'd2));
        push_word(exec_word(OPC_MUL, 3'd5, 3'd1, 3'd1));
        push_word(exec_word(OPC_DIV, 3'd6, 3'd1, 3'd3));
        push_word(exec_word(OPC_NAND, 3'd0, 3'd1, 3'd1));
        // conditional move with a zero and then a non-zero condition
        push_word(exec_word(OPC_CMOV, 3'd4, 3'd1, 3'd0));
        push_word(exec_word(OPC_CMOV, 3'd4, 3'd1, 3'd2));
        // output of the largest and the smallest character
        push_word(ldi_word(3'd6, 25'hff));
        push_word(exec_word(OPC_OUT, 3'd0, 3'd0, 3'd6));
        push_word(exec_word(OPC_OUT, 3'd0, 3'd0, 3'd0));
        // input of a character, then at end of stream
        w = exec_word(OPC_IN, 3'd0, 3'd0, 3'd5);
        w.in_char = 8'hab;
        w.in_eof  = 1'b0;
        push_word(w);
        w.in_char = 8'h00;
        w.in_eof  = 1'b1;
        push_word(w);
        // forwarded array operations, delete of array zero among them
        push_word(exec_word(OPC_LOAD, 3'd1, 3'd2, 3'd3));
        push_word(exec_word(OPC_STORE, 3'd1, 3'd2, 3'd3));
        push_word(exec_word(OPC_NEW, 3'd0, 3'd4, 3'd7));
        push_word(exec_word(OPC_DEL, 3'd0, 3'd0, 3'd0));
        push_word(exec_word(OPC_PROG, 3'd0, 3'd1, 3'd2));
        push_word(wb_word(3'd7, 32'd0));

        // random words in three idling mixes; the machine must not stop here
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 12;
                    recv_idle_pct = 64;
                end
                1:
                begin
                    send_idle_pct = 64;
                    recv_idle_pct = 12;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_req      = 1'b1;
                end
            endcase
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                a    = 3'($urandom_range(0, 7));
                b    = 3'($urandom_range(0, 7));
                c    = 3'($urandom_range(0, 7));
                if (pick < 20)
                    push_word(wb_word(a, rand_value()));
                else if (pick < 28)
                begin
                    // divide behind a write of a non-zero divisor
                    divisor = rand_value();
                    if (divisor == '0)
                        divisor = 32'd1;
                    push_word(wb_word(c, divisor));
                    push_word(exec_word(OPC_DIV, a, b, c));
                end
                else if (pick < 34)
                begin
                    // output behind a write of a legal character
                    push_word(wb_word(c, ($urandom_range(0, 3) == 0) ? CHAR_MAX
                                                                     : $urandom_range(0, 255)));
                    push_word(exec_word(OPC_OUT, a, b, c));
                end
                else
                    push_word(exec_word(safe_ops[4'($urandom_range(0, 10))], a, b, c));
            end
        end

        // one stopping event, then words against the stopped machine
        a = 3'($urandom_range(0, 7));
        b = 3'($urandom_range(0, 7));
        c = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 4))
            0:
            begin
                stop_kind = "halt";
                push_word(exec_word(OPC_HALT, a, b, c));
            end
            1:
            begin
                stop_kind = "invalid opcode 14";
                push_word(exec_word(OPC_BAD_LO, a, b, c));
            end
            2:
            begin
                stop_kind = "invalid opcode 15";
                push_word(exec_word(OPC_BAD_HI, a, b, c));
            end
            3:
            begin
                stop_kind = "divide by zero";
                push_word(wb_word(c, 32'd0));
                push_word(exec_word(OPC_DIV, a, b, c));
            end
            default:
            begin
                stop_kind = "bad output character";
                push_word(wb_word(c, CHAR_MAX + 32'd1 + $urandom_range(0, 1000)));
                push_word(exec_word(OPC_OUT, a, b, c));
            end
        endcase
        repeat (TAIL_WORDS)
        begin
            if ($urandom_range(0, 2) == 0)
                push_word(wb_word(3'($urandom_range(0, 7)), rand_value()));
            else
                push_word(exec_word(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                                    3'($urandom_range(0, 7)), 3'($urandom_range(0, 7))));
        end
        cmd_valid <= 1'b0;

        // drain
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d command words over three idling mixes and a %0d-cycle hold",
                 words_sent, HOLD_CYCLES);
        $display("%0d results checked; machine stopped at the end by %s", checked, stop_kind);
        if (errors == 0 && pending == 0)
            $display("PASS universal_machine_execute");
        else
            $display("FAIL universal_machine_execute");
        $finish;
    end

endmodule

// File: files.f
hdl/ume_pkg.sv
hdl/ume_div.sv
hdl/ume_dpath.sv
hdl/ume_ctrl.sv
hdl/universal_machine_execute.sv
tb/ume_exec_checker.sv
tb/tb_universal_machine_execute.sv
